### hw/rtl/assq_pkg.sv
// ----------------------------------------------------------------------------
// assq_pkg
// Types, constants and helpers shared by the alarm start/stop qualifier.
// ----------------------------------------------------------------------------
package assq_pkg;

  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned THR_WIDTH   = 16;
  localparam int unsigned CMP_WIDTH   = (COUNT_WIDTH > THR_WIDTH) ? COUNT_WIDTH : THR_WIDTH;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [THR_WIDTH-1:0]   thr_t;
  typedef logic [CMP_WIDTH-1:0]   cmp_t;

  localparam count_t CountMax = {COUNT_WIDTH{1'b1}};

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_THR   = 2'd0,
    CFG_HOLDOFF_THR = 2'd1,
    CFG_STOP_THR    = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_START = 2'd1,
    EV_STOP  = 2'd2
  } event_e;

  localparam logic REQ_FRAME = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  typedef struct packed {
    logic req_type;
    logic alarm_level;
  } req_t;

  typedef struct packed {
    logic [1:0] event_res;
    logic       alarm_active;
  } res_t;

  typedef struct packed {
    thr_t start_thr;
    thr_t holdoff_thr;
    thr_t stop_thr;
  } cfg_t;

  typedef struct packed {
    count_t rise_count;
    count_t fall_count;
    count_t holdoff_count;
    logic   started;
    logic   stop_armed;
    logic   holdoff_running;
  } state_t;

  function automatic count_t sat_inc(input count_t v);
    return (v == CountMax) ? v : count_t'(v + count_t'(1));
  endfunction

  function automatic logic cnt_gt_thr(input count_t c, input thr_t t);
    return cmp_t'(c) > cmp_t'(t);
  endfunction

endpackage

### hw/rtl/assq_core.sv
// ----------------------------------------------------------------------------
// assq_core
// Next-state and result logic for one qualifier step.
// ----------------------------------------------------------------------------
module assq_core import assq_pkg::*; (
  input  state_t state_i,
  input  cfg_t   cfg_i,
  input  req_t   req_i,
  output state_t state_o,
  output res_t   res_o
);

  count_t rise_n;
  count_t fall_n;
  count_t hold_n;
  state_t nxt;
  event_e ev;

  always_comb begin
    nxt    = state_i;
    ev     = EV_NONE;
    rise_n = (req_i.alarm_level && !state_i.started) ? sat_inc(state_i.rise_count) : '0;
    fall_n = (!req_i.alarm_level && state_i.stop_armed) ? sat_inc(state_i.fall_count) : '0;
    hold_n = state_i.holdoff_running ? sat_inc(state_i.holdoff_count) : state_i.holdoff_count;
    nxt.rise_count = rise_n;
    nxt.fall_count = fall_n;
    if (req_i.req_type == REQ_CLEAR) begin
      nxt = '0;
    end else if (cnt_gt_thr(rise_n, cfg_i.start_thr)) begin
      nxt.started         = 1'b1;
      nxt.holdoff_running = 1'b1;
      nxt.rise_count      = '0;
      ev                  = EV_START;
    end else begin
      nxt.holdoff_count = hold_n;
      if (cnt_gt_thr(hold_n, cfg_i.holdoff_thr)) begin
        nxt.stop_armed      = 1'b1;
        nxt.holdoff_running = 1'b0;
        nxt.holdoff_count   = '0;
      end
      if (cnt_gt_thr(fall_n, cfg_i.stop_thr)) begin
        nxt.stop_armed = 1'b0;
        nxt.started    = 1'b0;
        nxt.fall_count = '0;
        ev             = EV_STOP;
      end
    end
  end

  assign state_o            = nxt;
  assign res_o.event_res    = ev;
  assign res_o.alarm_active = nxt.started;

endmodule

### hw/rtl/assq_out_reg.sv
// ----------------------------------------------------------------------------
// assq_out_reg
// Result register with valid/stall handshake toward the consumer.
// ----------------------------------------------------------------------------
module assq_out_reg import assq_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  res_t res_i,
  input  logic out_stall_i,
  output logic out_valid_o,
  output res_t out_res_o,
  output logic busy_o
);

  logic valid_q, valid_d;
  res_t res_q;

  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_res_o   = res_q;
  // hold the upstream while an untaken result sits here
  assign busy_o      = valid_q & out_stall_i;

endmodule

### hw/rtl/alarm_start_stop_qualifier.sv
// ----------------------------------------------------------------------------
// alarm_start_stop_qualifier
// The result is valid in the cycle after its request is accepted.
// Takes one request per cycle while the output is not stalled, set by the single-step state update.
// Input stalls only while a finished result waits to be taken.
// Reset clears all qualifier state and loads thresholds 5 / 100 / 5.
// ----------------------------------------------------------------------------
module alarm_start_stop_qualifier import assq_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  thr_t                 cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  req_t                 in_req_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output res_t                 out_res_o
);

  cfg_t   cfg_q;
  state_t state_q, state_d;
  res_t   res_d;
  logic   busy;
  logic   accept;

  assign in_stall_o = busy;
  assign accept     = in_valid_i & ~busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_thr   <= thr_t'(5);
      cfg_q.holdoff_thr <= thr_t'(100);
      cfg_q.stop_thr    <= thr_t'(5);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_START_THR:   cfg_q.start_thr   <= cfg_data_i;
        CFG_HOLDOFF_THR: cfg_q.holdoff_thr <= cfg_data_i;
        CFG_STOP_THR:    cfg_q.stop_thr    <= cfg_data_i;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  assq_core u_core (
    .state_i (state_q),
    .cfg_i   (cfg_q),
    .req_i   (in_req_i),
    .state_o (state_d),
    .res_o   (res_d)
  );

  assq_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .res_i       (res_d),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_res_o   (out_res_o),
    .busy_o      (busy)
  );

endmodule

### dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the alarm start/stop qualifier. A queue-fed driver
// sends frame and clear requests with random gaps, a monitor takes results
// under random stall and compares each against a cycle-free predictor of the
// qualifier. Phases cover reset thresholds, zero thresholds, random settings
// and short runs with thresholds at and near the top of the range.
// ----------------------------------------------------------------------------
module tb;
  import assq_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;
  localparam int unsigned          CYCLE_LIMIT   = 100000;
  localparam int unsigned          SAT_RUN       = 12;
  localparam int unsigned          TOP_RUN       = 12;

  typedef struct {
    req_t        req;
    int unsigned gap;
  } frame_slot_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  thr_t                 cfg_data_i  = '0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  req_t                 in_req_i    = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  res_t                 out_res_o;

  frame_slot_t pending_q[$];
  res_t        verdict_q[$];
  frame_slot_t staged_slot;
  bit          staged    = 1'b0;
  int unsigned gap_left  = 0;
  int unsigned stall_left = 0;
  bit          quiet     = 1'b0;

  thr_t   thr_start = thr_t'(5);
  thr_t   thr_hold  = thr_t'(100);
  thr_t   thr_stop  = thr_t'(5);
  count_t rise_run  = '0;
  count_t fall_run  = '0;
  count_t hold_cnt  = '0;
  logic   alarm_on  = 1'b0;
  logic   armed     = 1'b0;
  logic   hold_run  = 1'b0;

  int unsigned errors     = 0;
  int unsigned accepted   = 0;
  int unsigned checked    = 0;
  int unsigned starts     = 0;
  int unsigned stops      = 0;
  int unsigned clears     = 0;
  int unsigned settings   = 0;
  int unsigned cycle_cnt  = 0;

  alarm_start_stop_qualifier i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_res_o   (out_res_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic count_t bump(input count_t c);
    return (c == CountMax) ? c : count_t'(c + 1'b1);
  endfunction

  function automatic res_t qualify(input req_t r);
    res_t v;
    v.event_res    = EV_NONE;
    v.alarm_active = 1'b0;
    if (r.req_type == REQ_CLEAR) begin
      rise_run = '0;
      fall_run = '0;
      hold_cnt = '0;
      alarm_on = 1'b0;
      armed    = 1'b0;
      hold_run = 1'b0;
      return v;
    end
    rise_run = (r.alarm_level && !alarm_on) ? bump(rise_run) : '0;
    fall_run = (!r.alarm_level && armed) ? bump(fall_run) : '0;
    if (rise_run > thr_start) begin
      alarm_on    = 1'b1;
      hold_run    = 1'b1;
      rise_run    = '0;
      v.event_res = EV_START;
    end else begin
      if (hold_run) hold_cnt = bump(hold_cnt);
      if (hold_cnt > thr_hold) begin
        armed    = 1'b1;
        hold_run = 1'b0;
        hold_cnt = '0;
      end
      if (fall_run > thr_stop) begin
        armed       = 1'b0;
        alarm_on    = 1'b0;
        fall_run    = '0;
        v.event_res = EV_STOP;
      end
    end
    v.alarm_active = alarm_on;
    return v;
  endfunction

  function automatic void report(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $time, msg);
  endfunction

  // request driver
  always @(posedge clk_i or negedge rst_ni) begin : req_drive
    logic next_valid;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_req_i   <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        verdict_q = {verdict_q, qualify(in_req_i)};
        accepted++;
      end
      next_valid = in_valid_i && in_stall_o;
      if (!next_valid) begin
        if (!staged && pending_q.size() != 0) begin
          staged_slot = pending_q.pop_front();
          staged      = 1'b1;
          gap_left    = staged_slot.gap;
        end
        if (staged) begin
          if (gap_left == 0) begin
            next_valid = 1'b1;
            in_req_i   <= staged_slot.req;
            staged     = 1'b0;
          end else begin
            gap_left--;
          end
        end
      end
      in_valid_i <= next_valid;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin : res_mon
    res_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        checked++;
        if (out_res_o.event_res == EV_START) starts++;
        if (out_res_o.event_res == EV_STOP) stops++;
        if (verdict_q.size() == 0) begin
          report($sformatf("result with nothing pending: event=%0d active=%0b",
                           out_res_o.event_res, out_res_o.alarm_active));
        end else begin
          want = verdict_q.pop_front();
          if (out_res_o.event_res !== want.event_res ||
              out_res_o.alarm_active !== want.alarm_active) begin
            report($sformatf({"result %0d: expected event=%0d active=%0b, ",
                              "got event=%0d active=%0b"},
                             checked, want.event_res, want.alarm_active,
                             out_res_o.event_res, out_res_o.alarm_active));
          end
        end
        stall_left = quiet ? 0 : $urandom_range(0, 3);
      end else if (out_valid_o && stall_left != 0) begin
        stall_left--;
      end
      out_stall_i <= (stall_left != 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending",
               cycle_cnt, verdict_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic push_req(input logic kind, input logic lvl);
    frame_slot_t s;
    @(negedge clk_i);
    while (pending_q.size() >= 8) @(negedge clk_i);
    s.req.req_type    = kind;
    s.req.alarm_level = lvl;
    s.gap             = quiet ? 0 : $urandom_range(0, 3);
    if (kind == REQ_CLEAR) clears++;
    pending_q = {pending_q, s};
  endtask

  task automatic frames(input logic lvl, input int unsigned n);
    repeat (n) push_req(REQ_FRAME, lvl);
  endtask

  task automatic wait_drained();
    while (pending_q.size() != 0 || staged || in_valid_i || verdict_q.size() != 0)
      @(negedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input thr_t data);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    case (idx)
      CFG_START_THR:   thr_start = data;
      CFG_HOLDOFF_THR: thr_hold  = data;
      CFG_STOP_THR:    thr_stop  = data;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(input thr_t s, input thr_t h, input thr_t p);
    wait_drained();
    set_reg(CFG_START_THR, s);
    set_reg(CFG_HOLDOFF_THR, h);
    set_reg(CFG_STOP_THR, p);
    set_reg(CFG_IDX_SPARE, thr_t'($urandom_range(0, 65535)));
    settings++;
  endtask

  function automatic thr_t pick_thr(input int unsigned hi);
    return ($urandom_range(0, 9) == 0) ? thr_t'(16'hFFFE) : thr_t'($urandom_range(0, hi));
  endfunction

  initial begin : stimulus
    int unsigned n;
    int unsigned len;
    logic        lvl;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset thresholds: start on the sixth high frame
    frames(1'b1, 6);
    push_req(REQ_CLEAR, 1'b1);

    // zero thresholds: every event fires as early as possible
    set_all('0, '0, '0);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_FRAME, 1'b0);
    push_req(REQ_FRAME, 1'b0);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_CLEAR, 1'b1);
    push_req(REQ_CLEAR, 1'b0);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_FRAME, 1'b0);
    push_req(REQ_FRAME, 1'b0);

    // random settings with run-length shaped alarm levels
    for (int ph = 0; ph < 5; ph++) begin
      set_all(pick_thr(6), pick_thr(10), pick_thr(6));
      quiet = (ph % 3 == 2);
      n = 0;
      while (n < 85) begin
        if ($urandom_range(0, 29) == 0) begin
          push_req(REQ_CLEAR, 1'($urandom_range(0, 1)));
          n++;
        end else begin
          lvl = 1'($urandom_range(0, 1));
          len = $urandom_range(1, 9);
          frames(lvl, len);
          n += len;
        end
      end
    end

    // thresholds at and near the top of the range
    quiet = 1'b1;
    set_all(16'hFFFF, '0, '0);
    frames(1'b1, SAT_RUN);
    push_req(REQ_CLEAR, 1'b0);

    set_all('0, 16'hFFFF, '0);
    push_req(REQ_FRAME, 1'b1);
    frames(1'b0, SAT_RUN);
    push_req(REQ_CLEAR, 1'b1);

    set_all('0, '0, 16'hFFFF);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_FRAME, 1'b0);
    frames(1'b0, SAT_RUN);
    push_req(REQ_FRAME, 1'b1);
    push_req(REQ_CLEAR, 1'b0);

    set_all(16'hFFFE, 16'hFFFE, 16'hFFFE);
    frames(1'b1, TOP_RUN);
    frames(1'b1, TOP_RUN);
    frames(1'b0, TOP_RUN);
    quiet = 1'b0;

    wait_drained();
    repeat (5) @(posedge clk_i);
    if (verdict_q.size() != 0)
      report($sformatf("%0d expected results never arrived", verdict_q.size()));

    $display("Sent %0d requests (%0d clears) over %0d threshold settings",
             accepted, clears, settings);
    $display("Checked %0d results: %0d starts, %0d stops, %0d mismatches",
             checked, starts, stops, errors);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
